@@ src/binomial_mod_prime_macros.svh @@
// Assertion macros shared by the checker of the binomial coefficient block.
`ifndef BINOMIAL_MOD_PRIME_MACROS_SVH
`define BINOMIAL_MOD_PRIME_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define BMP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("binomial_mod_prime: same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define BMP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("binomial_mod_prime: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define BMP_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("binomial_mod_prime: reset check failed");

`endif

@@ src/bmp_pkg.sv @@
// Constants and widths shared by the binomial coefficient modules.
`timescale 1ns / 1ps
package bmp_pkg;
   localparam int ModWidth     = 30;
   localparam int TopWidth     = 12;
   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 32;
   localparam int ExpBits      = 30;
   localparam int ExpIdxWidth  = 5;

   localparam logic [ModWidth-1:0] Prime       = 30'd998244353;
   localparam logic [31:0]         PrimeWide   = 32'd998244353;
   localparam logic [31:0]         PrimeTwice  = 32'd1996488706;
   localparam logic [ExpBits-1:0]  InvExponent = 30'd998244351;
   localparam logic [63:0]         BarrettFull = (64'd1 << 60) / 64'd998244353;
   localparam logic [30:0]         BarrettMu   = BarrettFull[30:0];
endpackage

@@ src/bmp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bmp_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/bmp_mulmod.sv @@
// Five-stage pipelined modular multiplier with Barrett reduction by the prime.
`timescale 1ns / 1ps
module bmp_mulmod
   import bmp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [ModWidth-1:0] in_a,
   input  logic [ModWidth-1:0] in_b,
   output logic                out_valid,
   output logic [ModWidth-1:0] out_value
);
   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [59:0]         prod_ff;
   logic [61:0]         quot_ff;
   logic [31:0]         low2_ff, low3_ff;
   logic [31:0]         qp_ff;
   logic [31:0]         rem_ff;
   logic [ModWidth-1:0] result_ff;
   logic [31:0]         rem_in;

   always_comb begin
      if (rem_ff >= PrimeTwice) begin
         rem_in = rem_ff - PrimeTwice;
      end else if (rem_ff >= PrimeWide) begin
         rem_in = rem_ff - PrimeWide;
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      prod_ff   <= 60'(in_a) * 60'(in_b);
      quot_ff   <= 62'(prod_ff[59:29]) * 62'(BarrettMu);
      low2_ff   <= prod_ff[31:0];
      qp_ff     <= 32'(quot_ff[61:31]) * PrimeWide;
      low3_ff   <= low2_ff;
      rem_ff    <= low3_ff - qp_ff;
      result_ff <= rem_in[ModWidth-1:0];
   end

   assign out_valid = v5_ff;
   assign out_value = result_ff;
endmodule

@@ src/binomial_mod_prime.sv @@
// Top level: n choose k modulo 998244353 from a factorial table and a Fermat inverse.
`timescale 1ns / 1ps
// Usage:
// A query word enters on the req_ channel: top (n) in bits 11:0, pick (k) in bits 23:12.
// One result word leaves on the rsp_ channel: the coefficient in bits 29:0.
// After reset the block fills its factorial RAM with i! mod p, one entry per pass
// through the shared modular multiplier, and req_tready stays low until the fill ends.
// A query is worked on alone. Three RAM reads fetch n!, k! and (n-k)!, the multiplier
// forms the denominator, and the inverse comes from square-and-multiply over the 30
// exponent bits through the five-stage multiplier pipeline. A query with k greater
// than n, or n outside the table, skips the multiplier and answers zero.
// The next query is accepted as soon as the previous result sits in the output
// register, so one result may wait on a stalled receiver while the next is computed;
// a finished result then holds until the output register frees up.
// Reset is synchronous, clears the response valid and restarts the table fill.
module binomial_mod_prime
   import bmp_pkg::*;
#(
   parameter int TABLE_SIZE = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,   // top [11:0], pick [23:12]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata    // coefficient [29:0], zero [31:30]
);
   localparam int AddrWidth = $clog2(TABLE_SIZE);
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(TABLE_SIZE - 1);

   typedef enum logic [3:0] {
      S_INIT_ONE,
      S_INIT_MUL,
      S_INIT_WAIT,
      S_IDLE,
      S_RD_K,
      S_RD_NK,
      S_RD_N,
      S_DEN,
      S_LATCH_N,
      S_DEN_WAIT,
      S_EXP_A,
      S_EXP_B,
      S_EXP_WA,
      S_EXP_WB,
      S_FINAL,
      S_FINISH
   } state_type;

   state_type               state_ff;
   logic [AddrWidth-1:0]    idx_ff;
   logic [ModWidth-1:0]     prev_ff;
   logic [TopWidth-1:0]     top_ff, pick_ff;
   logic [ModWidth-1:0]     fk_ff, fn_ff, acc_ff, base_ff, res_ff;
   logic [ExpIdxWidth-1:0]  bit_ff;
   logic                    rsp_valid_ff;
   logic [ModWidth-1:0]     rsp_data_ff;

   logic                    ram_wr_en;
   logic [AddrWidth-1:0]    ram_wr_addr;
   logic [ModWidth-1:0]     ram_wr_data;
   logic [AddrWidth-1:0]    ram_rd_addr;
   logic [ModWidth-1:0]     ram_rd_data;
   logic                    mul_valid;
   logic [ModWidth-1:0]     mul_a, mul_b;
   logic                    mul_out_valid;
   logic [ModWidth-1:0]     mul_out;

   logic [TopWidth-1:0]     req_top, req_pick, diff;
   logic                    req_accept, req_zero;

   assign req_top    = req_tdata[TopWidth-1:0];
   assign req_pick   = req_tdata[2*TopWidth-1:TopWidth];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_zero   = (req_pick > req_top) || (int'(req_top) >= TABLE_SIZE);
   assign diff       = top_ff - pick_ff;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = mul_out;
      ram_rd_addr = AddrWidth'(top_ff);
      mul_valid   = 1'b0;
      mul_a       = acc_ff;
      mul_b       = base_ff;
      unique case (state_ff)
         S_INIT_ONE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = ModWidth'(1);
         end
         S_INIT_MUL: begin
            mul_valid = 1'b1;
            mul_a     = prev_ff;
            mul_b     = ModWidth'(idx_ff);
         end
         S_INIT_WAIT: begin
            ram_wr_en = mul_out_valid;
         end
         S_RD_NK: ram_rd_addr = AddrWidth'(pick_ff);
         S_RD_N:  ram_rd_addr = AddrWidth'(diff);
         S_DEN: begin
            mul_valid = 1'b1;
            mul_a     = fk_ff;
            mul_b     = ram_rd_data;
         end
         S_EXP_A: mul_valid = 1'b1;
         S_EXP_B: begin
            mul_valid = 1'b1;
            mul_a     = base_ff;
         end
         S_FINAL: begin
            mul_valid = 1'b1;
            mul_a     = fn_ff;
            mul_b     = acc_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_ONE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT_ONE: begin
               prev_ff  <= ModWidth'(1);
               idx_ff   <= AddrWidth'(1);
               state_ff <= S_INIT_MUL;
            end
            S_INIT_MUL: state_ff <= S_INIT_WAIT;
            S_INIT_WAIT: begin
               if (mul_out_valid) begin
                  prev_ff <= mul_out;
                  if (idx_ff == LastAddr) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + AddrWidth'(1);
                     state_ff <= S_INIT_MUL;
                  end
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  top_ff  <= req_top;
                  pick_ff <= req_pick;
                  if (req_zero) begin
                     res_ff   <= '0;
                     state_ff <= S_FINISH;
                  end else begin
                     state_ff <= S_RD_K;
                  end
               end
            end
            S_RD_K:  state_ff <= S_RD_NK;
            S_RD_NK: state_ff <= S_RD_N;
            S_RD_N: begin
               fk_ff    <= ram_rd_data;
               state_ff <= S_DEN;
            end
            S_DEN:     state_ff <= S_LATCH_N;
            S_LATCH_N: begin
               fn_ff    <= ram_rd_data;
               state_ff <= S_DEN_WAIT;
            end
            S_DEN_WAIT: begin
               if (mul_out_valid) begin
                  base_ff  <= mul_out;
                  acc_ff   <= ModWidth'(1);
                  bit_ff   <= '0;
                  state_ff <= S_EXP_A;
               end
            end
            S_EXP_A: state_ff <= S_EXP_B;
            S_EXP_B: state_ff <= S_EXP_WA;
            S_EXP_WA: begin
               if (mul_out_valid) begin
                  if (InvExponent[bit_ff]) begin
                     acc_ff <= mul_out;
                  end
                  state_ff <= S_EXP_WB;
               end
            end
            S_EXP_WB: begin
               if (mul_out_valid) begin
                  base_ff <= mul_out;
                  if (bit_ff == ExpIdxWidth'(ExpBits - 1)) begin
                     state_ff <= S_FINAL;
                  end else begin
                     bit_ff   <= bit_ff + ExpIdxWidth'(1);
                     state_ff <= S_EXP_A;
                  end
               end
            end
            S_FINAL: begin
               if (mul_out_valid) begin
                  res_ff   <= mul_out;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   bmp_ram #(
      .WIDTH (ModWidth),
      .DEPTH (TABLE_SIZE)
   ) u_fact_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bmp_mulmod u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_a      (mul_a),
      .in_b      (mul_b),
      .out_valid (mul_out_valid),
      .out_value (mul_out)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataWidth'(rsp_data_ff);
endmodule

@@ src/binomial_mod_prime_checker.sv @@
// Port-level checker for the binomial coefficient block and its bind.
`timescale 1ns / 1ps
`include "binomial_mod_prime_macros.svh"
module binomial_mod_prime_checker
   import bmp_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);
   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   // The table fill follows reset, so no word is taken right after it.
   `BMP_ASSERT_RESET(a_fill_blocks_req, reset, !req_tready && !rsp_tvalid)
   // Queries are worked on one at a time.
   `BMP_ASSERT_NEXT(a_one_query, req_fire, !req_tready)
   // Every result is a residue below the prime.
   `BMP_ASSERT_NOW(a_residue, rsp_tvalid,
      (rsp_tdata[RspDataWidth-1:ModWidth] == '0) && (rsp_tdata[ModWidth-1:0] < Prime))
   // A stalled result holds.
   `BMP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
endmodule

bind binomial_mod_prime binomial_mod_prime_checker u_checker (.*);

@@ tb/sv/tb_binomial_mod_prime.sv @@
// Self-checking testbench for the binomial coefficient block modulo 998244353.
`timescale 1ns / 1ps
module tb_binomial_mod_prime
   import bmp_pkg::*;
();

   localparam int TableSize = 4096;
   localparam int DrainCycles = 400;

   typedef struct {
      logic [TopWidth-1:0] top;
      logic [TopWidth-1:0] pick;
      bit                  drain;
   } query_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   logic [ModWidth-1:0]     fact_mod [TableSize];
   query_type               pending_queries [$];
   logic [ModWidth-1:0]     expected_coeffs [$];
   int                      outstanding = 0;
   int                      issued_count = 0;
   int                      mismatch_count = 0;
   bit                      calm = 1'b0;

   binomial_mod_prime #(.TABLE_SIZE(TableSize)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [ModWidth-1:0] mul_mod(logic [ModWidth-1:0] a,
                                                   logic [ModWidth-1:0] b);
      logic [63:0] wide;
      wide = 64'(a) * 64'(b);
      return ModWidth'(wide % 64'(Prime));
   endfunction

   function automatic logic [ModWidth-1:0] choose_mod(logic [TopWidth-1:0] n,
                                                      logic [TopWidth-1:0] k);
      logic [ModWidth-1:0] den;
      logic [ModWidth-1:0] inv;
      logic [ModWidth-1:0] base;
      logic [ExpBits-1:0]  e;
      if (k > n || int'(n) >= TableSize) return '0;
      den  = mul_mod(fact_mod[k], fact_mod[n - k]);
      inv  = ModWidth'(1);
      base = den;
      e    = InvExponent;
      while (e != 0) begin
         if (e[0]) inv = mul_mod(inv, base);
         base = mul_mod(base, base);
         e = e >> 1;
      end
      return mul_mod(fact_mod[n], inv);
   endfunction

   task automatic add_query(int top, int pick, bit drain = 1'b0);
      query_type q;
      q.top   = TopWidth'(top);
      q.pick  = TopWidth'(pick);
      q.drain = drain;
      pending_queries.push_back(q);
   endtask

   task automatic note_error(string what, logic [RspDataWidth-1:0] want,
                             logic [RspDataWidth-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected %0d, got %0d", what, want, got);
   endtask

   initial begin
      int top;
      int pick;
      int choice;
      fact_mod[0] = ModWidth'(1);
      for (int i = 1; i < TableSize; i++)
         fact_mod[i] = mul_mod(fact_mod[i - 1], ModWidth'(i));

      add_query(0, 0);
      add_query(4095, 4095);
      add_query(4095, 0);
      add_query(0, 4095);
      add_query(4095, 2048);
      add_query(4095, 2047);
      add_query(1, 0);
      add_query(1, 1);
      add_query(0, 1);
      add_query(4094, 4095);
      add_query(4095, 4094);
      add_query(4095, 1);
      add_query(2048, 2049);
      add_query(2730, 1365);
      add_query(1365, 2730);
      add_query(3000, 1500);
      add_query(12, 6);
      add_query(2, 1);
      add_query(4095, 4095, 1'b1);

      for (int i = 0; i < 1230; i++) begin
         choice = $urandom_range(99);
         if (choice < 12) begin
            top  = $urandom_range(4094);
            pick = $urandom_range(4095, top + 1);
         end else if (choice < 25) begin
            top  = $urandom_range(20);
            pick = $urandom_range(top);
         end else begin
            top  = $urandom_range(4095);
            pick = $urandom_range(top);
         end
         add_query(top, pick, i == 600);
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin : drive
      query_type q;
      bit        accepted;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         accepted = req_tvalid && req_tready;
         if (accepted) issued_count++;
         calm <= issued_count >= 400 && issued_count < 650;
         if (!req_tvalid || accepted) begin
            if (pending_queries.size() != 0 &&
                !(pending_queries[0].drain && (outstanding != 0 || accepted)) &&
                (calm || $urandom_range(99) >= 10)) begin
               q = pending_queries.pop_front();
               req_tdata  <= {q.pick, q.top};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : observe
      logic [ModWidth-1:0] want;
      if (reset) begin
         rsp_tready  <= 1'b0;
         outstanding <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_coeffs.push_back(choose_mod(req_tdata[TopWidth-1:0],
                                                 req_tdata[2*TopWidth-1:TopWidth]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_coeffs.size() == 0) begin
               note_error("Result word with no query waiting", '0, rsp_tdata);
            end else begin
               want = expected_coeffs.pop_front();
               if (rsp_tdata[ModWidth-1:0] !== want)
                  note_error("Coefficient mismatch", RspDataWidth'(want), rsp_tdata);
               if (rsp_tdata[RspDataWidth-1:ModWidth] !== '0)
                  note_error("Nonzero pad bits", '0, rsp_tdata);
            end
         end
         outstanding <= expected_coeffs.size();
         rsp_tready  <= calm || $urandom_range(99) >= 10;
      end
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      while (pending_queries.size() != 0 || req_tvalid || outstanding != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (expected_coeffs.size() != 0) begin
         mismatch_count++;
         $display("%0d expected results never arrived", expected_coeffs.size());
      end
      if (mismatch_count == 0) begin
         $display("tb_binomial_mod_prime: clean");
      end else begin
         $display("tb_binomial_mod_prime: errors");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_binomial_mod_prime: errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/bmp_pkg.sv
src/bmp_ram.sv
src/bmp_mulmod.sv
src/binomial_mod_prime.sv
src/binomial_mod_prime_checker.sv
tb/sv/tb_binomial_mod_prime.sv
